[rtl/gamepad_button_edge_autorepeat_top_assert.svh]
// assertion macros shared by the gamepad poll block checkers
`ifndef GAMEPAD_BUTTON_EDGE_AUTOREPEAT_TOP_ASSERT_SVH
`define GAMEPAD_BUTTON_EDGE_AUTOREPEAT_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GBEA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gbea assertion failed");

// next-cycle implication, checked outside reset
`define GBEA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gbea assertion failed");

`endif

[rtl/gbea_pkg.sv]
// shared types, constants and helpers of the gamepad poll block
`default_nettype none
package gbea_pkg;

    localparam int NUM_BUTTONS = 22;
    localparam int TIME_BITS   = 24;
    localparam int IDX_W       = $clog2(NUM_BUTTONS);
    localparam int DELAY_W     = 16;
    localparam int THR_W       = 7;
    localparam int ELAPSED_W   = 16;
    localparam int STICK_W     = 8;
    localparam int QUERY_W     = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_DATA_W    = 80;
    localparam int M_DATA_W    = 120;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    localparam int BIT_UP    = 0;
    localparam int BIT_DOWN  = 1;
    localparam int BIT_LEFT  = 2;
    localparam int BIT_RIGHT = 3;

    localparam logic [DELAY_W-1:0] RESET_REPEAT_DELAY    = 16'd512;
    localparam logic [THR_W-1:0]   RESET_STICK_THRESHOLD = 7'd50;

    typedef logic [NUM_BUTTONS-1:0] btn_mask_t;
    typedef logic [3:0]             dir_bits_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPEAT_DELAY    = 2'd0,
        CFG_STICK_THRESHOLD = 2'd1,
        CFG_LEFT_TO_DPAD    = 2'd2,
        CFG_RIGHT_TO_DPAD   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic [DELAY_W-1:0] repeat_delay;
        logic [THR_W-1:0]   stick_threshold;
        logic               left_to_dpad;
        logic               right_to_dpad;
    } cfg_t;

    typedef struct packed {
        btn_mask_t                   raw_buttons;
        logic signed [STICK_W-1:0]   left_x;
        logic signed [STICK_W-1:0]   left_y;
        logic signed [STICK_W-1:0]   right_x;
        logic signed [STICK_W-1:0]   right_y;
        logic [ELAPSED_W-1:0]        elapsed_time;
        logic                        digital_mode;
        logic [QUERY_W-1:0]          query_button;
    } poll_in_t;

    // poll outcome handed from the edge logic to the timer sweep
    typedef struct packed {
        btn_mask_t            on;
        btn_mask_t            rise;
        btn_mask_t            fall;
        btn_mask_t            pressed_out;
        logic [ELAPSED_W-1:0] elapsed_time;
    } poll_res_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] held;
        logic [TIME_BITS-1:0] released;
    } time_entry_t;

    function automatic dir_bits_t stick_bits(input logic signed [STICK_W-1:0] x,
                                             input logic signed [STICK_W-1:0] y,
                                             input logic [THR_W-1:0] t);
        logic signed [STICK_W:0] sx;
        logic signed [STICK_W:0] sy;
        logic signed [STICK_W:0] st;
        dir_bits_t               b;
        sx = {x[STICK_W-1], x};
        sy = {y[STICK_W-1], y};
        st = signed'({2'b00, t});
        b  = '0;
        if (sx >= st) begin
            b[BIT_RIGHT] = 1'b1;
        end else if (sx <= -st) begin
            b[BIT_LEFT] = 1'b1;
        end
        if (sy >= st) begin
            b[BIT_DOWN] = 1'b1;
        end else if (sy <= -st) begin
            b[BIT_UP] = 1'b1;
        end
        return b;
    endfunction

    function automatic logic in_deadzone(input logic signed [STICK_W-1:0] x,
                                         input logic signed [STICK_W-1:0] y,
                                         input logic [THR_W-1:0] t);
        logic signed [STICK_W:0] sx;
        logic signed [STICK_W:0] sy;
        logic signed [STICK_W:0] st;
        sx = {x[STICK_W-1], x};
        sy = {y[STICK_W-1], y};
        st = signed'({2'b00, t});
        return (sx > -st) && (sx < st) && (sy > -st) && (sy < st);
    endfunction

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [ELAPSED_W-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + (TIME_BITS+1)'(b);
        return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/gamepad_button_edge_autorepeat_top.sv]
// gamepad poll block: button edges, per-button timers and direction auto-repeat
//
// One beat on the s_ channel is one controller poll; it yields exactly one
// beat on the m_ channel with held, pressed and released masks and the held
// and released times of the queried button.
// The poll beat updates previous buttons and the repeat timers at once, then
// the per-button timer memory is swept one entry per cycle (read, then
// modify and write back the next cycle); then a drain state, and a done
// state that loads the output register once it is free. A new poll is
// taken only back in the idle state, in which s_tready is high.
// s_tready is high only while no poll is in work. The result sits in an
// output register, so a stalled m_ channel does not hold up the next poll;
// only the following result waits until the register is taken.
// Configuration beats on the cfg_ channel are always taken and should come
// while the block is idle. Reset restores the register defaults (delay 512,
// threshold 50, sticks off) and zeroes all buttons, timers and times.
`default_nettype none
module gamepad_button_edge_autorepeat_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // raw_buttons, left_x, left_y, right_x, right_y, elapsed_time,
    // digital_mode, query_button, zero pad
    input  wire logic [gbea_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // held_buttons, pressed_buttons, released_buttons, query_held_time,
    // query_released_time, zero pad
    output logic [gbea_pkg::M_DATA_W-1:0]          m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gbea_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gbea_pkg::CFG_DATA_W-1:0]   cfg_data
);

    gbea_pkg::cfg_t             cfg_reg;
    gbea_pkg::poll_in_t         item;
    gbea_pkg::poll_res_t        res;
    gbea_pkg::time_entry_t      rd_data, wr_data;
    logic [gbea_pkg::IDX_W-1:0] rd_addr, wr_addr;
    logic                       wr_en;
    logic                       accept;
    gbea_pkg::btn_mask_t        out_held, out_pressed, out_released;
    logic [gbea_pkg::TIME_BITS-1:0] out_held_time, out_released_time;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.repeat_delay    <= gbea_pkg::RESET_REPEAT_DELAY;
            cfg_reg.stick_threshold <= gbea_pkg::RESET_STICK_THRESHOLD;
            cfg_reg.left_to_dpad    <= 1'b0;
            cfg_reg.right_to_dpad   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (gbea_pkg::cfg_index_t'(cfg_index))
                gbea_pkg::CFG_REPEAT_DELAY: begin
                    cfg_reg.repeat_delay <= cfg_data;
                end
                gbea_pkg::CFG_STICK_THRESHOLD: begin
                    cfg_reg.stick_threshold <= cfg_data[gbea_pkg::THR_W-1:0];
                end
                gbea_pkg::CFG_LEFT_TO_DPAD: begin
                    cfg_reg.left_to_dpad <= cfg_data[0];
                end
                gbea_pkg::CFG_RIGHT_TO_DPAD: begin
                    cfg_reg.right_to_dpad <= cfg_data[0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // unpack the poll beat
    assign item.raw_buttons  = s_tdata[21:0];
    assign item.left_x       = s_tdata[29:22];
    assign item.left_y       = s_tdata[37:30];
    assign item.right_x      = s_tdata[45:38];
    assign item.right_y      = s_tdata[53:46];
    assign item.elapsed_time = s_tdata[69:54];
    assign item.digital_mode = s_tdata[70];
    assign item.query_button = s_tdata[75:71];

    assign accept = s_tvalid && s_tready;

    gbea_poll u_poll (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .cfg     (cfg_reg),
        .item    (item),
        .res     (res)
    );

    gbea_tmem u_tmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    gbea_seq u_seq (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .accept            (accept),
        .query_in          (item.query_button),
        .res               (res),
        .in_ready          (s_tready),
        .rd_addr           (rd_addr),
        .rd_data           (rd_data),
        .wr_en             (wr_en),
        .wr_addr           (wr_addr),
        .wr_data           (wr_data),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_held          (out_held),
        .out_pressed       (out_pressed),
        .out_released      (out_released),
        .out_held_time     (out_held_time),
        .out_released_time (out_released_time)
    );

    assign m_tdata = {6'd0, out_released_time, out_held_time,
                      out_released, out_pressed, out_held};

endmodule
`default_nettype wire

[rtl/gbea_tmem.sv]
// per-button held and released time memory with a registered read
`default_nettype none
module gbea_tmem (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [gbea_pkg::IDX_W-1:0]    rd_addr,
    output gbea_pkg::time_entry_t              rd_data,
    input  wire logic                          wr_en,
    input  wire logic [gbea_pkg::IDX_W-1:0]    wr_addr,
    input  wire gbea_pkg::time_entry_t         wr_data
);

    gbea_pkg::time_entry_t             mem [gbea_pkg::NUM_BUTTONS];
    logic [gbea_pkg::NUM_BUTTONS-1:0]  valid_reg;
    gbea_pkg::time_entry_t             rd_data_reg;
    logic                              rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // entries never written since reset read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

[rtl/gbea_poll.sv]
// stick to direction conversion, repeat timers and edge detection per poll
`default_nettype none
module gbea_poll (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire gbea_pkg::cfg_t    cfg,
    input  wire gbea_pkg::poll_in_t item,
    output gbea_pkg::poll_res_t    res
);

    gbea_pkg::btn_mask_t            prev_held_reg, prev_held_next;
    logic [gbea_pkg::DELAY_W-1:0]   left_timer_reg, left_timer_next;
    logic [gbea_pkg::DELAY_W-1:0]   right_timer_reg, right_timer_next;
    logic [gbea_pkg::DELAY_W-1:0]   dir_timer_reg, dir_timer_next;
    gbea_pkg::poll_res_t            res_reg, res_next;

    logic [gbea_pkg::DELAY_W-1:0]   left_clamp, right_clamp, dir_clamp;
    logic [gbea_pkg::DELAY_W-1:0]   dt;
    gbea_pkg::dir_bits_t            left_bits, right_bits;
    gbea_pkg::btn_mask_t            on, pressed;

    always_comb begin
        dt          = item.elapsed_time;
        left_clamp  = (left_timer_reg > cfg.repeat_delay) ? cfg.repeat_delay : left_timer_reg;
        right_clamp = (right_timer_reg > cfg.repeat_delay) ? cfg.repeat_delay : right_timer_reg;
        dir_clamp   = (dir_timer_reg > cfg.repeat_delay) ? cfg.repeat_delay : dir_timer_reg;
        left_bits   = gbea_pkg::stick_bits(item.left_x, item.left_y, cfg.stick_threshold);
        right_bits  = gbea_pkg::stick_bits(item.right_x, item.right_y, cfg.stick_threshold);

        on               = item.raw_buttons;
        left_timer_next  = left_clamp;
        right_timer_next = right_clamp;
        dir_timer_next   = dir_clamp;

        if (item.digital_mode && cfg.left_to_dpad) begin
            if (left_bits == '0) begin
                left_timer_next = '0;
            end else if (left_clamp <= dt) begin
                // timer would reach zero or below
                on[3:0]         = on[3:0] | left_bits;
                left_timer_next = cfg.repeat_delay;
            end else begin
                left_timer_next = left_clamp - dt;
            end
        end

        if (item.digital_mode && cfg.right_to_dpad) begin
            if (gbea_pkg::in_deadzone(item.right_x, item.right_y, cfg.stick_threshold)) begin
                right_timer_next = '0;
            end else if (right_clamp <= dt) begin
                on[3:0]          = on[3:0] | right_bits;
                right_timer_next = cfg.repeat_delay;
            end else begin
                right_timer_next = right_clamp - dt;
            end
        end

        pressed        = on & ~prev_held_reg;
        prev_held_next = on;

        res_next.on           = on;
        res_next.rise         = pressed;
        res_next.fall         = prev_held_reg & ~on;
        res_next.elapsed_time = item.elapsed_time;

        if (item.digital_mode) begin
            if (on[3:0] == '0) begin
                dir_timer_next = '0;
            end else begin
                if (dir_clamp <= dt) begin
                    dir_timer_next = cfg.repeat_delay;
                    if (on[gbea_pkg::BIT_UP]) begin
                        pressed[gbea_pkg::BIT_UP] = 1'b1;
                    end else if (on[gbea_pkg::BIT_DOWN]) begin
                        pressed[gbea_pkg::BIT_DOWN] = 1'b1;
                    end
                end else begin
                    dir_timer_next = dir_clamp - dt;
                end
                // horizontal direction repeats on every poll
                if (on[gbea_pkg::BIT_LEFT]) begin
                    pressed[gbea_pkg::BIT_LEFT] = 1'b1;
                end else if (on[gbea_pkg::BIT_RIGHT]) begin
                    pressed[gbea_pkg::BIT_RIGHT] = 1'b1;
                end
            end
        end
        res_next.pressed_out = pressed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_held_reg   <= '0;
            left_timer_reg  <= '0;
            right_timer_reg <= '0;
            dir_timer_reg   <= '0;
        end else if (load) begin
            prev_held_reg   <= prev_held_next;
            left_timer_reg  <= left_timer_next;
            right_timer_reg <= right_timer_next;
            dir_timer_reg   <= dir_timer_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

[rtl/gbea_seq.sv]
// sweep sequencer: read-modify-write of the button timers and result register
`default_nettype none
module gbea_seq (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          accept,
    input  wire logic [gbea_pkg::QUERY_W-1:0]  query_in,
    input  wire gbea_pkg::poll_res_t           res,
    output logic                               in_ready,
    output logic [gbea_pkg::IDX_W-1:0]         rd_addr,
    input  wire gbea_pkg::time_entry_t         rd_data,
    output logic                               wr_en,
    output logic [gbea_pkg::IDX_W-1:0]         wr_addr,
    output gbea_pkg::time_entry_t              wr_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output gbea_pkg::btn_mask_t                out_held,
    output gbea_pkg::btn_mask_t                out_pressed,
    output gbea_pkg::btn_mask_t                out_released,
    output logic [gbea_pkg::TIME_BITS-1:0]     out_held_time,
    output logic [gbea_pkg::TIME_BITS-1:0]     out_released_time
);

    localparam logic [gbea_pkg::IDX_W-1:0] LAST_IDX = gbea_pkg::IDX_W'(gbea_pkg::NUM_BUTTONS - 1);

    gbea_pkg::seq_state_t               state_reg, state_next;
    logic [gbea_pkg::IDX_W-1:0]         idx_reg, idx_next;
    logic                               wr_pend_reg, wr_pend_next;
    logic [gbea_pkg::IDX_W-1:0]         wr_idx_reg;
    logic [gbea_pkg::QUERY_W-1:0]       query_reg;
    logic [gbea_pkg::TIME_BITS-1:0]     qh_reg, qr_reg;
    logic                               m_valid_reg, m_valid_next;
    logic                               load_out;
    gbea_pkg::time_entry_t              upd;
    gbea_pkg::btn_mask_t                held_out_reg, pressed_out_reg, released_out_reg;
    logic [gbea_pkg::TIME_BITS-1:0]     qh_out_reg, qr_out_reg;
    logic                               query_hit;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            gbea_pkg::ST_IDLE: begin
                if (accept) begin
                    idx_next   = '0;
                    state_next = gbea_pkg::ST_SWEEP;
                end
            end
            gbea_pkg::ST_SWEEP: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = gbea_pkg::ST_DRAIN;
                end
            end
            gbea_pkg::ST_DRAIN: begin
                state_next = gbea_pkg::ST_DONE;
            end
            gbea_pkg::ST_DONE: begin
                if (!m_valid_reg || out_ready) begin
                    load_out   = 1'b1;
                    state_next = gbea_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gbea_pkg::ST_IDLE;
            end
        endcase
        wr_pend_next = (state_reg == gbea_pkg::ST_SWEEP);
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (out_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // modify the entry read in the previous cycle
    always_comb begin
        upd = rd_data;
        if (res.rise[wr_idx_reg]) begin
            upd.held = '0;
        end else if (res.fall[wr_idx_reg]) begin
            upd.released = '0;
        end
        if (res.on[wr_idx_reg]) begin
            upd.held = gbea_pkg::sat_add(upd.held, res.elapsed_time);
        end else begin
            upd.released = gbea_pkg::sat_add(upd.released, res.elapsed_time);
        end
        query_hit = wr_pend_reg && (gbea_pkg::QUERY_W'(wr_idx_reg) == query_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gbea_pkg::ST_IDLE;
            idx_reg     <= '0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_idx_reg <= idx_reg;
        if (accept) begin
            query_reg <= query_in;
            // a query beyond the button count never hits and reports zero
            qh_reg    <= '0;
            qr_reg    <= '0;
        end else if (query_hit) begin
            qh_reg <= upd.held;
            qr_reg <= upd.released;
        end
        if (load_out) begin
            held_out_reg     <= res.on;
            pressed_out_reg  <= res.pressed_out;
            released_out_reg <= res.fall;
            qh_out_reg       <= qh_reg;
            qr_out_reg       <= qr_reg;
        end
    end

    assign in_ready          = (state_reg == gbea_pkg::ST_IDLE);
    assign rd_addr           = idx_reg;
    assign wr_en             = wr_pend_reg;
    assign wr_addr           = wr_idx_reg;
    assign wr_data           = upd;
    assign out_valid         = m_valid_reg;
    assign out_held          = held_out_reg;
    assign out_pressed       = pressed_out_reg;
    assign out_released      = released_out_reg;
    assign out_held_time     = qh_out_reg;
    assign out_released_time = qr_out_reg;

endmodule
`default_nettype wire

[rtl/gbea_checker.sv]
// port-level checker for the gamepad poll block, bound to the top level
`default_nettype none
`include "gamepad_button_edge_autorepeat_top_assert.svh"
module gbea_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [gbea_pkg::M_DATA_W-1:0]   m_tdata
);

    // a stalled result beat holds
    `GBEA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one poll at a time: input closes right after a beat is taken
    `GBEA_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // a button cannot be held and released in the same poll
    `GBEA_ASSERT_NOW(a_held_released_disjoint, aclk, aresetn, m_tvalid, (m_tdata[65:44] & m_tdata[21:0]) == 22'd0)

    // every pressed bit, repeated or not, is also held
    `GBEA_ASSERT_NOW(a_pressed_in_held, aclk, aresetn, m_tvalid, (m_tdata[43:22] & ~m_tdata[21:0]) == 22'd0)

endmodule

bind gamepad_button_edge_autorepeat_top gbea_checker u_gbea_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
